### rtl/kvi_pkg.sv
// kvi_pkg: shared types and constants for the keyframe vector interpolator
// used by every rtl file of the block; depends on nothing
`default_nettype none

package kvi_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned SLOT_W       = 6;
  localparam int unsigned CNT_W        = 7;
  localparam int unsigned SEG_W        = 6;
  localparam int unsigned FRAC_BITS    = 24;
  localparam int unsigned FRAC_W       = FRAC_BITS + 1;
  localparam int unsigned MAX_KEYS_DEF = 64;
  localparam logic [CNT_W-1:0] KEY_COUNT_RST = CNT_W'(1);
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  typedef enum logic [0:0] {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FETCH0,
    ST_FETCH1,
    ST_FETCH2,
    ST_DIV,
    ST_BLEND,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    COMP_X = 2'd0,
    COMP_Y = 2'd1,
    COMP_Z = 2'd2
  } comp_e;

  typedef struct packed {
    logic [DATA_W-1:0] ktime;
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
  } key_t;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] num;
    logic [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              valid;
    comp_e             comp;
    logic [DATA_W-1:0] start_val;
    logic [DATA_W-1:0] end_val;
    logic [FRAC_W-1:0] frac;
  } blend_req_t;

endpackage

`default_nettype wire

### rtl/keyframe_vector_interpolator_unit.sv
// keyframe_vector_interpolator_unit: linear keyframe track lookup, one item at a time
// the key search reads one key per cycle from the single read port of the key memory,
// then the 24-step divider and the shared lerp unit (3 components, 2 stages) follow
// reset clears the sequencer, output valid and key_count (to 1); key memory is not cleared
`default_nettype none

module keyframe_vector_interpolator_unit #(
  parameter int unsigned MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire [kvi_pkg::CNT_W-1:0]            cfg_wdata_i,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  wire                                 opcode_i,
  input  wire [kvi_pkg::SLOT_W-1:0]           key_slot_i,
  input  wire [kvi_pkg::DATA_W-1:0]           key_time_i,
  input  wire signed [kvi_pkg::DATA_W-1:0]    value_x_i,
  input  wire signed [kvi_pkg::DATA_W-1:0]    value_y_i,
  input  wire signed [kvi_pkg::DATA_W-1:0]    value_z_i,
  input  wire [kvi_pkg::DATA_W-1:0]           query_time_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output logic signed [kvi_pkg::DATA_W-1:0]   result_x_o,
  output logic signed [kvi_pkg::DATA_W-1:0]   result_y_o,
  output logic signed [kvi_pkg::DATA_W-1:0]   result_z_o,
  output logic [kvi_pkg::SEG_W-1:0]           segment_index_o
);

  localparam int unsigned AW = $clog2(MAX_KEYS);
  localparam int unsigned NW = $clog2(MAX_KEYS + 1);

  kvi_pkg::state_e               state_q, state_d;
  logic [kvi_pkg::CNT_W-1:0]     key_count_q;
  logic [kvi_pkg::DATA_W-1:0]    qtime_q, qtime_d;
  logic [AW-1:0]                 scan_addr_q, scan_addr_d;
  logic [AW-1:0]                 chk_idx_q, chk_idx_d;
  logic                          chk_valid_q, chk_valid_d;
  logic [AW-1:0]                 seg_q, seg_d;
  logic                          found_q, found_d;
  logic                          single_q, single_d;
  kvi_pkg::key_t                 k0_q, k0_d;
  kvi_pkg::key_t                 k1_q, k1_d;
  logic [kvi_pkg::FRAC_W-1:0]    f_q, f_d;
  logic [1:0]                    issue_q, issue_d;
  logic [kvi_pkg::DATA_W-1:0]    rx_q, rx_d, ry_q, ry_d, rz_q, rz_d;
  logic                          out_valid_q, out_valid_d;
  logic [kvi_pkg::DATA_W-1:0]    ox_q, ox_d, oy_q, oy_d, oz_q, oz_d;
  logic [kvi_pkg::SEG_W-1:0]     oseg_q, oseg_d;

  logic [31:0]                   cnt32, n32;
  logic [NW-1:0]                 n_keys;
  logic [AW-1:0]                 last;
  logic                          in_acc, out_acc;
  logic                          mem_we;
  logic [AW-1:0]                 mem_raddr;
  kvi_pkg::key_t                 mem_wdata, mem_rdata;
  kvi_pkg::div_req_t             div_req;
  logic                          div_done;
  logic [kvi_pkg::FRAC_BITS-1:0] div_quot;
  kvi_pkg::blend_req_t           bl_req;
  logic                          bl_valid;
  kvi_pkg::comp_e                bl_comp;
  logic signed [kvi_pkg::DATA_W-1:0] bl_res;

  // effective key count: zero acts as one, clipped to the memory depth
  assign cnt32 = 32'(key_count_q);
  always_comb begin
    if (cnt32 == 32'd0) begin
      n32 = 32'd1;
    end else if (cnt32 > MAX_KEYS) begin
      n32 = MAX_KEYS;
    end else begin
      n32 = cnt32;
    end
  end
  assign n_keys = NW'(n32);
  assign last   = AW'(n_keys - NW'(1));

  assign in_stall_o = (state_q != kvi_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_acc    = out_valid_q && !out_stall_i;

  assign mem_we = in_acc && (opcode_i == kvi_pkg::OP_LOAD)
                && (32'(key_slot_i) < MAX_KEYS);
  assign mem_wdata = '{ktime: key_time_i, x: value_x_i, y: value_y_i, z: value_z_i};

  kvi_keymem #(
    .MAX_KEYS (MAX_KEYS),
    .AW       (AW)
  ) u_keymem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (AW'(key_slot_i)),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  kvi_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  kvi_blend_unit u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (bl_req),
    .valid_o (bl_valid),
    .comp_o  (bl_comp),
    .res_o   (bl_res)
  );

  always_comb begin
    bl_req.valid = (state_q == kvi_pkg::ST_BLEND) && (issue_q <= 2'(kvi_pkg::COMP_Z));
    bl_req.frac  = f_q;
    case (issue_q)
      2'(kvi_pkg::COMP_X): begin
        bl_req.comp      = kvi_pkg::COMP_X;
        bl_req.start_val = k0_q.x;
        bl_req.end_val   = k1_q.x;
      end
      2'(kvi_pkg::COMP_Y): begin
        bl_req.comp      = kvi_pkg::COMP_Y;
        bl_req.start_val = k0_q.y;
        bl_req.end_val   = k1_q.y;
      end
      default: begin
        bl_req.comp      = kvi_pkg::COMP_Z;
        bl_req.start_val = k0_q.z;
        bl_req.end_val   = k1_q.z;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    qtime_d     = qtime_q;
    scan_addr_d = scan_addr_q;
    chk_idx_d   = chk_idx_q;
    chk_valid_d = chk_valid_q;
    seg_d       = seg_q;
    found_d     = found_q;
    single_d    = single_q;
    k0_d        = k0_q;
    k1_d        = k1_q;
    f_d         = f_q;
    issue_d     = issue_q;
    rx_d        = rx_q;
    ry_d        = ry_q;
    rz_d        = rz_q;
    out_valid_d = out_valid_q && !out_acc;
    ox_d        = ox_q;
    oy_d        = oy_q;
    oz_d        = oz_q;
    oseg_d      = oseg_q;
    mem_raddr   = scan_addr_q;
    div_req     = '{start: 1'b0, num: qtime_q - k0_q.ktime, den: k1_q.ktime - k0_q.ktime};

    unique case (state_q)
      kvi_pkg::ST_IDLE: begin
        if (in_acc && (opcode_i == kvi_pkg::OP_QUERY)) begin
          qtime_d     = query_time_i;
          scan_addr_d = AW'(1);
          chk_valid_d = 1'b0;
          seg_d       = '0;
          found_d     = 1'b0;
          single_d    = (n_keys == NW'(1));
          state_d     = (n_keys == NW'(1)) ? kvi_pkg::ST_FETCH0 : kvi_pkg::ST_SCAN;
        end
      end
      kvi_pkg::ST_SCAN: begin
        // one key time read per cycle; the compare sees the read from the cycle before
        mem_raddr   = scan_addr_q;
        chk_valid_d = 1'b1;
        chk_idx_d   = scan_addr_q;
        if (scan_addr_q < last) begin
          scan_addr_d = scan_addr_q + AW'(1);
        end
        if (chk_valid_q) begin
          if (qtime_q < mem_rdata.ktime) begin
            seg_d   = chk_idx_q - AW'(1);
            found_d = 1'b1;
            state_d = kvi_pkg::ST_FETCH0;
          end else if (chk_idx_q == last) begin
            seg_d   = last - AW'(1);
            found_d = 1'b0;
            state_d = kvi_pkg::ST_FETCH0;
          end
        end
      end
      kvi_pkg::ST_FETCH0: begin
        mem_raddr = seg_q;
        state_d   = kvi_pkg::ST_FETCH1;
      end
      kvi_pkg::ST_FETCH1: begin
        mem_raddr = seg_q + AW'(1);
        k0_d      = mem_rdata;
        state_d   = kvi_pkg::ST_FETCH2;
      end
      kvi_pkg::ST_FETCH2: begin
        k1_d    = mem_rdata;
        issue_d = 2'(kvi_pkg::COMP_X);
        div_req = '{start: 1'b0, num: qtime_q - k0_q.ktime,
                    den: mem_rdata.ktime - k0_q.ktime};
        if (single_q) begin
          f_d     = '0;
          state_d = kvi_pkg::ST_BLEND;
        end else if (!found_q) begin
          f_d     = kvi_pkg::FRAC_ONE;
          state_d = kvi_pkg::ST_BLEND;
        end else if ((mem_rdata.ktime <= k0_q.ktime) || (qtime_q < k0_q.ktime)) begin
          f_d     = '0;
          state_d = kvi_pkg::ST_BLEND;
        end else begin
          div_req.start = 1'b1;
          state_d       = kvi_pkg::ST_DIV;
        end
      end
      kvi_pkg::ST_DIV: begin
        if (div_done) begin
          f_d     = {1'b0, div_quot};
          state_d = kvi_pkg::ST_BLEND;
        end
      end
      kvi_pkg::ST_BLEND: begin
        if (issue_q <= 2'(kvi_pkg::COMP_Z)) begin
          issue_d = issue_q + 2'd1;
        end
        if (bl_valid) begin
          case (bl_comp)
            kvi_pkg::COMP_X: rx_d = bl_res;
            kvi_pkg::COMP_Y: ry_d = bl_res;
            default: begin
              rz_d    = bl_res;
              state_d = kvi_pkg::ST_DONE;
            end
          endcase
        end
      end
      kvi_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          ox_d        = rx_q;
          oy_d        = ry_q;
          oz_d        = rz_q;
          oseg_d      = kvi_pkg::SEG_W'(seg_q);
          state_d     = kvi_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kvi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= kvi_pkg::ST_IDLE;
      key_count_q <= kvi_pkg::KEY_COUNT_RST;
      out_valid_q <= 1'b0;
      chk_valid_q <= 1'b0;
      issue_q     <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chk_valid_q <= chk_valid_d;
      issue_q     <= issue_d;
      if (cfg_we_i) begin
        key_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    qtime_q     <= qtime_d;
    scan_addr_q <= scan_addr_d;
    chk_idx_q   <= chk_idx_d;
    seg_q       <= seg_d;
    found_q     <= found_d;
    single_q    <= single_d;
    k0_q        <= k0_d;
    k1_q        <= k1_d;
    f_q         <= f_d;
    rx_q        <= rx_d;
    ry_q        <= ry_d;
    rz_q        <= rz_d;
    ox_q        <= ox_d;
    oy_q        <= oy_d;
    oz_q        <= oz_d;
    oseg_q      <= oseg_d;
  end

  assign out_valid_o     = out_valid_q;
  assign result_x_o      = ox_q;
  assign result_y_o      = oy_q;
  assign result_z_o      = oz_q;
  assign segment_index_o = oseg_q;

`ifndef SYNTHESIS
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == kvi_pkg::ST_DIV))
    else $error("divider finished outside the divide step");

  a_blend_in_blend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bl_valid |-> (state_q == kvi_pkg::ST_BLEND))
    else $error("lerp result arrived outside the blend step");

  a_seg_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == kvi_pkg::ST_FETCH1) && !single_q) |-> (seg_q < last))
    else $error("segment start beyond the last segment");

  a_frac_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == kvi_pkg::ST_BLEND) |-> (f_q <= kvi_pkg::FRAC_ONE))
    else $error("fraction above one");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == kvi_pkg::ST_DONE))
    else $error("result shown without a finished query");
`endif

endmodule

`default_nettype wire

### rtl/kvi_keymem.sv
// kvi_keymem: key storage, one write port and one registered read port
// one entry holds a key time and its x, y, z values; uses kvi_pkg
`default_nettype none

module kvi_keymem #(
  parameter int unsigned MAX_KEYS = kvi_pkg::MAX_KEYS_DEF,
  parameter int unsigned AW       = $clog2(MAX_KEYS)
) (
  input  wire               clk_i,
  input  wire               we_i,
  input  wire [AW-1:0]      waddr_i,
  input  kvi_pkg::key_t     wdata_i,
  input  wire [AW-1:0]      raddr_i,
  output kvi_pkg::key_t     rdata_o
);

  kvi_pkg::key_t mem [MAX_KEYS];
  kvi_pkg::key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/kvi_divider.sv
// kvi_divider: restoring divider giving floor(num * 2^24 / den), one bit per cycle
// expects num < den; uses kvi_pkg
`default_nettype none

module kvi_divider (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  kvi_pkg::div_req_t              req_i,
  output logic                           done_o,
  output logic [kvi_pkg::FRAC_BITS-1:0]  quot_o
);

  localparam int unsigned CW = $clog2(kvi_pkg::FRAC_BITS + 1);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [CW-1:0]                  cnt_q, cnt_d;
  logic [kvi_pkg::DATA_W:0]       rem_q, rem_d;
  logic [kvi_pkg::DATA_W-1:0]     den_q, den_d;
  logic [kvi_pkg::FRAC_BITS-1:0]  quot_q, quot_d;
  logic [kvi_pkg::DATA_W:0]       rem_sh;
  logic [kvi_pkg::DATA_W+1:0]     diff;

  // remainder stays below den, so the shifted value fits in 33 bits
  assign rem_sh = {rem_q[kvi_pkg::DATA_W-1:0], 1'b0};
  assign diff   = {1'b0, rem_sh} - {2'b00, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = CW'(kvi_pkg::FRAC_BITS);
      rem_d  = {1'b0, req_i.num};
      den_d  = req_i.den;
      quot_d = '0;
    end else if (busy_q) begin
      if (!diff[kvi_pkg::DATA_W+1]) begin
        rem_d  = diff[kvi_pkg::DATA_W:0];
        quot_d = {quot_q[kvi_pkg::FRAC_BITS-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        quot_d = {quot_q[kvi_pkg::FRAC_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

### rtl/kvi_blend_unit.sv
// kvi_blend_unit: shared two-stage lerp unit, start + (end - start) * frac
// multiply in stage one, round to nearest and saturate in stage two; uses kvi_pkg
`default_nettype none

module kvi_blend_unit (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  kvi_pkg::blend_req_t                  req_i,
  output logic                                 valid_o,
  output kvi_pkg::comp_e                       comp_o,
  output logic signed [kvi_pkg::DATA_W-1:0]    res_o
);

  localparam int unsigned DW   = kvi_pkg::DATA_W + 1;
  localparam int unsigned PW   = DW + kvi_pkg::FRAC_W + 1;
  localparam int unsigned OW   = PW - kvi_pkg::FRAC_BITS;
  localparam int unsigned SW   = OW + 1;

  logic signed [DW-1:0]              diff;
  logic signed [DW-1:0]              diff_op;
  logic signed [PW-1:0]              prod_d, prod_q;
  logic signed [kvi_pkg::DATA_W-1:0] start_q;
  logic                              v1_q, v2_q;
  kvi_pkg::comp_e                    comp1_q, comp2_q;
  logic signed [PW-1:0]              rnd;
  logic signed [OW-1:0]              off;
  logic signed [SW-1:0]              sum;
  logic signed [kvi_pkg::DATA_W-1:0] sat;
  logic signed [kvi_pkg::DATA_W-1:0] res_q;

  assign diff = $signed({req_i.end_val[kvi_pkg::DATA_W-1], req_i.end_val})
              - $signed({req_i.start_val[kvi_pkg::DATA_W-1], req_i.start_val});
  // a zero fraction must not pull in the end key at all
  assign diff_op = (req_i.frac == '0) ? '0 : diff;
  assign prod_d  = diff_op * $signed({1'b0, req_i.frac});

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    start_q <= $signed(req_i.start_val);
    comp1_q <= req_i.comp;
    comp2_q <= comp1_q;
    res_q   <= sat;
  end

  // half an lsb added, then an arithmetic shift: ties go toward +infinity
  assign rnd = prod_q + (PW'(1) <<< (kvi_pkg::FRAC_BITS - 1));
  assign off = OW'(rnd >>> kvi_pkg::FRAC_BITS);
  assign sum = SW'(start_q) + SW'(off);

  always_comb begin
    if (sum > SW'(32'sh7fffffff)) begin
      sat = 32'sh7fffffff;
    end else if (sum < -SW'(33'sh080000000)) begin
      sat = 32'sh80000000;
    end else begin
      sat = sum[kvi_pkg::DATA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.valid;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign comp_o  = comp2_q;
  assign res_o   = res_q;

endmodule

`default_nettype wire

### tb/keyframe_vector_interpolator_unit_tb.sv
// testbench for keyframe_vector_interpolator_unit: loads keyframe tracks, queries them
// and checks every result against a track predictor; depends on kvi_pkg and the unit
`default_nettype none

module keyframe_vector_interpolator_unit_tb;
  import kvi_pkg::*;

  localparam int MAXK = MAX_KEYS_DEF;
  localparam int HOLD_OFF = 200;
  localparam int QUIET_LIMIT = 4000;
  localparam int ITEM_TARGET = 1400;
  localparam logic [63:0] FULL_FRAC = 64'd1 << FRAC_BITS;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483648;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] ktime;
    logic [DATA_W-1:0] vx;
    logic [DATA_W-1:0] vy;
    logic [DATA_W-1:0] vz;
    logic [DATA_W-1:0] qtime;
  } stim_t;

  typedef struct packed {
    logic [DATA_W-1:0] x;
    logic [DATA_W-1:0] y;
    logic [DATA_W-1:0] z;
    logic [SEG_W-1:0]  seg;
  } point_t;

  class track_checker;
    logic [DATA_W-1:0] key_time [MAXK];
    logic [DATA_W-1:0] key_x [MAXK];
    logic [DATA_W-1:0] key_y [MAXK];
    logic [DATA_W-1:0] key_z [MAXK];
    logic [CNT_W-1:0] count_reg = KEY_COUNT_RST;
    point_t expected_points[$];
    int failures = 0;

    function int pending();
      return expected_points.size();
    endfunction

    function void set_count(logic [CNT_W-1:0] v);
      count_reg = v;
    endfunction

    // round to nearest at the fraction point, ties toward +inf, then saturate
    function logic [DATA_W-1:0] lerp(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b,
                                     logic [63:0] f);
      longint s;
      longint d;
      longint p;
      longint r;
      s = longint'(signed'(a));
      d = longint'(signed'(b)) - s;
      p = d * longint'(f);
      r = s + ((p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      if (r > SAT_HI) r = SAT_HI;
      else if (r < SAT_LO) r = SAT_LO;
      return r[DATA_W-1:0];
    endfunction

    function point_t eval_track(logic [DATA_W-1:0] q);
      int n;
      int seg;
      int i;
      bit found;
      logic [DATA_W-1:0] t0;
      logic [DATA_W-1:0] t1;
      logic [63:0] frac;
      point_t p;
      n = (count_reg == 0) ? 1 : (count_reg > MAXK) ? MAXK : int'(count_reg);
      if (n == 1) begin
        p.x = key_x[0];
        p.y = key_y[0];
        p.z = key_z[0];
        p.seg = '0;
        return p;
      end
      seg = n - 2;
      found = 1'b0;
      for (i = 0; i + 1 < n; i++) begin
        if (!found && q < key_time[i+1]) begin
          seg = i;
          found = 1'b1;
        end
      end
      t0 = key_time[seg];
      t1 = key_time[seg+1];
      // past the last key holds the end key, degenerate segments hold the start key
      if (!found) begin
        frac = FULL_FRAC;
      end else if (t1 <= t0 || q < t0) begin
        frac = '0;
      end else begin
        frac = ({32'b0, q - t0} << FRAC_BITS) / {32'b0, t1 - t0};
        if (frac > FULL_FRAC) frac = FULL_FRAC;
      end
      p.x = lerp(key_x[seg], key_x[seg+1], frac);
      p.y = lerp(key_y[seg], key_y[seg+1], frac);
      p.z = lerp(key_z[seg], key_z[seg+1], frac);
      p.seg = seg[SEG_W-1:0];
      return p;
    endfunction

    function void note_item(stim_t s);
      if (s.op == OP_LOAD) begin
        if (s.slot < MAXK) begin
          key_time[s.slot] = s.ktime;
          key_x[s.slot] = s.vx;
          key_y[s.slot] = s.vy;
          key_z[s.slot] = s.vz;
        end
      end else begin
        expected_points.push_back(eval_track(s.qtime));
      end
    endfunction

    function void check_result(point_t got);
      point_t want;
      if (expected_points.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result x=%h y=%h z=%h seg=%0d", got.x, got.y, got.z, got.seg);
        return;
      end
      want = expected_points.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.z !== want.z || got.seg !== want.seg)
      begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected x=%h y=%h z=%h seg=%0d, got x=%h y=%h z=%h seg=%0d",
                   want.x, want.y, want.z, want.seg, got.x, got.y, got.z, got.seg);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = OP_LOAD;
  logic [SLOT_W-1:0] key_slot = '0;
  logic [DATA_W-1:0] key_time = '0;
  logic [DATA_W-1:0] value_x = '0;
  logic [DATA_W-1:0] value_y = '0;
  logic [DATA_W-1:0] value_z = '0;
  logic [DATA_W-1:0] query_time = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [DATA_W-1:0] result_x;
  logic [DATA_W-1:0] result_y;
  logic [DATA_W-1:0] result_z;
  logic [SEG_W-1:0] segment_index;

  track_checker chk = new();
  bit calm = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;
  logic [DATA_W-1:0] track_time [MAXK];

  keyframe_vector_interpolator_unit dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .opcode_i       (opcode),
    .key_slot_i     (key_slot),
    .key_time_i     (key_time),
    .value_x_i      (value_x),
    .value_y_i      (value_y),
    .value_z_i      (value_z),
    .query_time_i   (query_time),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .result_x_o     (result_x),
    .result_y_o     (result_y),
    .result_z_o     (result_z),
    .segment_index_o(segment_index)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 13);
  end

  // observe every transaction on both channels and the register port
  always @(posedge clk) begin
    bit moved;
    moved = 1'b0;
    if (rst_n) begin
      if (cfg_we) begin
        chk.set_count(cfg_wdata);
        moved = 1'b1;
      end
      if (in_valid && !in_stall) begin
        chk.note_item('{opcode, key_slot, key_time, value_x, value_y, value_z, query_time});
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        chk.check_result('{result_x, result_y, result_z, segment_index});
        moved = 1'b1;
      end
      if (moved) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
  end

  task automatic send(input stim_t s);
    if (!calm && $urandom_range(99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(5, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= s.op;
    key_slot <= s.slot;
    key_time <= s.ktime;
    value_x <= s.vx;
    value_y <= s.vy;
    value_z <= s.vz;
    query_time <= s.qtime;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  function automatic stim_t noise_item();
    stim_t s;
    s.op = ($urandom_range(1) == 0) ? OP_LOAD : OP_QUERY;
    s.slot = $urandom_range(MAXK - 1);
    s.ktime = $urandom;
    s.vx = $urandom;
    s.vy = $urandom;
    s.vz = $urandom;
    s.qtime = $urandom;
    return s;
  endfunction

  task automatic load_key(input int slot, input logic [DATA_W-1:0] t,
                          input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                          input logic [DATA_W-1:0] z);
    stim_t s;
    s = noise_item();
    s.op = OP_LOAD;
    s.slot = slot;
    s.ktime = t;
    s.vx = x;
    s.vy = y;
    s.vz = z;
    track_time[slot] = t;
    send(s);
  endtask

  task automatic query(input logic [DATA_W-1:0] q);
    stim_t s;
    s = noise_item();
    s.op = OP_QUERY;
    s.qtime = q;
    send(s);
  endtask

  // drain all results, let a trailing load finish, then write the key count
  task automatic begin_phase(input logic [CNT_W-1:0] cnt);
    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= cnt;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count(int phase);
    case (phase)
      0:       return 7'd127;
      1:       return 7'd0;
      2:       return 7'd64;
      3:       return 7'd1;
      4:       return 7'd65;
      5:       return 7'd2;
      default: begin
        if ($urandom_range(99) < 12) return $urandom_range(127, 9);
        return $urandom_range(8, 0);
      end
    endcase
  endfunction

  // key times: ascending buckets over the whole range, or a dense run with repeats
  task automatic load_track(input int n);
    int mode;
    int i;
    int slot;
    logic [63:0] bucket;
    logic [DATA_W-1:0] t;
    mode = $urandom_range(2);
    bucket = 64'h1_0000_0000 / n;
    t = $urandom_range(32'h00FF_FFFF);
    for (i = 0; i < n; i++) begin
      slot = ($urandom_range(1) == 0) ? i : n - 1 - i;
      if (mode == 0) begin
        t = DATA_W'(slot * bucket + ($urandom % bucket));
      end else begin
        t = track_time_base(slot, t, mode);
      end
      load_key(slot, t, pick_value(), pick_value(), pick_value());
    end
  endtask

  // dense tracks: a key's time is the seed's low 24 bits plus one random step per slot below it
  function automatic logic [DATA_W-1:0] track_time_base(int slot, logic [DATA_W-1:0] seed,
                                                        int mode);
    logic [DATA_W-1:0] t;
    int k;
    t = seed & 32'h00FF_FFFF;
    for (k = 1; k <= slot; k++) begin
      if (mode == 1) t = t + (($urandom_range(7) == 0) ? 0 : $urandom_range(32'h3_FFFF));
      else t = t + $urandom_range(3);
    end
    return t;
  endfunction

  function automatic logic [DATA_W-1:0] pick_query(int n);
    int k;
    logic [DATA_W-1:0] span;
    k = $urandom_range(n - 1);
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return '0;
      2:       return 32'hFFFF_FFFF;
      3, 4:    return track_time[k] + $urandom_range(6) - 3;
      default: begin
        if (k == n - 1) k = (n > 1) ? n - 2 : 0;
        if (n == 1 || track_time[k+1] <= track_time[k]) return track_time[k];
        span = track_time[k+1] - track_time[k];
        return track_time[k] + ($urandom % span);
      end
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    int count_in_phase;
    int j;
    int slot;
    logic [CNT_W-1:0] cnt;
    stim_t s;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single key after reset, with the widest field values
    load_key(0, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    query(32'h0000_0000);
    query(32'hFFFF_FFFF);
    // a count of zero behaves as one key
    begin_phase(7'd0);
    query(32'h0001_2345);
    // before the first key, mid segment, repeated time, near and at the last key
    begin_phase(7'd4);
    load_key(0, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
    load_key(1, 32'h0001_8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000);
    load_key(2, 32'h0001_8000, 32'd5, -32'sd5, 32'd0);
    load_key(3, 32'hFFFF_FFFF, 32'h1234_5678, 32'hEDCB_A988, 32'h7FFF_FFFF);
    query(32'd0);
    query(32'h0000_C000);
    query(32'h0001_8000);
    query(32'hFFFF_FFFE);
    query(32'hFFFF_FFFF);
    // rounding ties in both directions, then a descending last segment
    begin_phase(7'd2);
    load_key(0, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
    load_key(1, 32'd2, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    query(32'd1);
    query(32'd0);
    query(32'd2);
    begin_phase(7'd3);
    load_key(2, 32'd1, 32'd7, 32'd8, 32'd9);
    query(32'd1);

    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      cnt = pick_count(phase);
      n = (cnt == 0) ? 1 : (cnt > MAXK) ? MAXK : int'(cnt);
      begin_phase(cnt);
      calm <= (phase >= 6 && phase <= 8);
      load_track(n);
      count_in_phase = $urandom_range(40, 15);
      for (j = 0; j < count_in_phase; j++) begin
        if ($urandom_range(99) < 10) begin
          // stray load: a slot outside the track, or a key overwritten out of order
          s = noise_item();
          s.op = OP_LOAD;
          if (n < MAXK && $urandom_range(1) == 0) slot = $urandom_range(MAXK - 1, n);
          else slot = $urandom_range(n - 1);
          s.slot = slot;
          if (slot < n) track_time[slot] = s.ktime;
          send(s);
        end else begin
          query(pick_query(n));
        end
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (chk.pending() != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
    if (chk.failures == 0 && chk.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/kvi_pkg.sv
rtl/kvi_keymem.sv
rtl/kvi_divider.sv
rtl/kvi_blend_unit.sv
rtl/keyframe_vector_interpolator_unit.sv
tb/keyframe_vector_interpolator_unit_tb.sv
